### rtl/hba_pkg.sv
package hba_pkg;

  localparam int MAX_CELLS_DEF = 16384;
  localparam int CELL_W        = 32;
  localparam int HALF_W        = 16;
  localparam int ID_W          = 31;
  localparam int BIN_W         = 16;
  localparam int AXIS_W        = 15;
  localparam int PROD_W        = 2 * AXIS_W;
  localparam int SUM_W         = PROD_W + 1;
  localparam int CFG_DATA_W    = 31;
  localparam int CFG_IDX_W     = 3;

  localparam logic MODE_FILL = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_HIST_ID    = 3'd1,
    REG_TWO_DIM    = 3'd2,
    REG_X_BINS     = 3'd3,
    REG_Y_BINS     = 3'd4,
    REG_WIDE_CELLS = 3'd5
  } hba_reg_t;

  typedef struct packed {
    logic              enable;
    logic [ID_W-1:0]   hist_id;
    logic              two_dim;
    logic [AXIS_W-1:0] x_bins;
    logic [AXIS_W-1:0] y_bins;
    logic              wide_cells;
  } hba_cfg_t;

  typedef struct packed {
    logic clearing;
  } hba_bstat_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC
  } hba_bstate_t;

  function automatic int idx_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

### rtl/hba_if.sv
interface hba_in_if
  import hba_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [ID_W-1:0]         req_id;
  logic signed [BIN_W-1:0] x;
  logic signed [BIN_W-1:0] y;
  logic signed [CELL_W-1:0] weight;

  modport source (output valid, mode, req_id, x, y, weight, input ready);
  modport sink   (input valid, mode, req_id, x, y, weight, output ready);
endinterface

interface hba_out_if
  import hba_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [CELL_W-1:0] cell_value;

  modport source (output valid, accepted, cell_value, input ready);
  modport sink   (input valid, accepted, cell_value, output ready);
endinterface

### rtl/hba_ram.sv
module hba_ram
  import hba_pkg::*;
#(
  parameter int WIDTH = CELL_W,
  parameter int DEPTH = MAX_CELLS_DEF,
  localparam int AW   = idx_width(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/hba_front.sv
module hba_front
  import hba_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  localparam int IDX_W    = idx_width(MAX_CELLS),
  localparam int JOB_W    = 2 + CELL_W + IDX_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hba_cfg_t         cfg,
  input  hba_bstat_t       bstat,
  hba_in_if.sink           in_ch,
  output logic             push_valid,
  input  logic             push_ready,
  output logic [JOB_W-1:0] push_data
);

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_mode_r;
  logic              s1_ok_r;
  logic [AXIS_W-1:0] s1_x_r;
  logic [PROD_W-1:0] s1_prod_r;
  logic [CELL_W-1:0] s1_weight_r;

  logic              take;
  logic              x_ok, y_ok, id_ok, en_ok;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  idx_full;
  logic              idx_ok;

  always_comb begin
    x_ok  = !in_ch.x[BIN_W-1] && (in_ch.x[AXIS_W-1:0] < cfg.x_bins);
    y_ok  = !cfg.two_dim || (!in_ch.y[BIN_W-1] && (in_ch.y[AXIS_W-1:0] < cfg.y_bins));
    id_ok = (in_ch.req_id == cfg.hist_id);
    en_ok = (in_ch.mode == MODE_READ) || cfg.enable;
    prod  = cfg.two_dim ? (PROD_W'(in_ch.y[AXIS_W-1:0]) * PROD_W'(cfg.x_bins)) : '0;
  end

  assign in_ch.ready = !bstat.clearing && (!s1_valid_r || push_ready);
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (push_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_mode_r   <= in_ch.mode;
      s1_ok_r     <= x_ok && y_ok && id_ok && en_ok;
      s1_x_r      <= in_ch.x[AXIS_W-1:0];
      s1_prod_r   <= prod;
      s1_weight_r <= in_ch.weight;
    end
  end

  assign idx_full   = SUM_W'(s1_prod_r) + SUM_W'(s1_x_r);
  assign idx_ok     = (idx_full < SUM_W'(MAX_CELLS));
  assign push_valid = s1_valid_r;
  assign push_data  = {s1_mode_r, s1_ok_r && idx_ok, s1_weight_r, idx_full[IDX_W-1:0]};

endmodule

### rtl/hba_queue.sv
module hba_queue
  import hba_pkg::*;
#(
  parameter int WIDTH = CELL_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

### rtl/hba_back.sv
module hba_back
  import hba_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEF,
  localparam int IDX_W    = idx_width(MAX_CELLS),
  localparam int JOB_W    = 2 + CELL_W + IDX_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hba_cfg_t         cfg,
  output hba_bstat_t       bstat,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  logic [JOB_W-1:0] pop_data,
  hba_out_if.source        out_ch
);

  hba_bstate_t       state_r, state_nxt;
  logic [IDX_W-1:0]  clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_acc_r;
  logic [CELL_W-1:0] out_val_r;

  logic              ex_mode_r, ex_ok_r;
  logic [CELL_W-1:0] ex_weight_r;
  logic [IDX_W-1:0]  ex_idx_r;

  logic              j_mode, j_ok;
  logic [CELL_W-1:0] j_weight;
  logic [IDX_W-1:0]  j_idx;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic              pop, out_free, load;
  logic [CELL_W-1:0] cur, sum, val, res;

  assign {j_mode, j_ok, j_weight, j_idx} = pop_data;

  hba_ram #(
    .WIDTH (CELL_W),
    .DEPTH (MAX_CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (j_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur = cfg.wide_cells ? ram_rdata : {{HALF_W{1'b0}}, ram_rdata[HALF_W-1:0]};
    sum = cur + ex_weight_r;
    if (!cfg.wide_cells) begin
      sum[CELL_W-1:HALF_W] = '0;
    end
    val = (ex_mode_r == MODE_READ) ? cur : sum;
    res = ex_ok_r ? val : '0;
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    ram_we    = 1'b0;
    ram_waddr = ex_idx_r;
    ram_wdata = val;
    ram_re    = 1'b0;
    pop_ready = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == IDX_W'(MAX_CELLS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          ram_re    = 1'b1;
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        if (out_free) begin
          load      = 1'b1;
          ram_we    = ex_ok_r && (ex_mode_r == MODE_FILL);
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign pop = pop_valid && pop_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ex_mode_r   <= j_mode;
      ex_ok_r     <= j_ok;
      ex_weight_r <= j_weight;
      ex_idx_r    <= j_idx;
    end
    if (load) begin
      out_acc_r <= ex_ok_r;
      out_val_r <= res;
    end
  end

  assign bstat.clearing    = (state_r == B_CLEAR);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.accepted   = out_acc_r;
  assign out_ch.cell_value = out_val_r;

endmodule

### rtl/histogram_bin_accumulator.sv
// Histogram bin accumulator. After reset the block first zeroes its cell store, one
// cell per cycle, so in_ch.ready stays low until every cell is cleared; configuration
// writes are taken during that time. The front stage checks id, enable and bin
// ranges, registers the item and computes the row-major cell index, then hands it
// to a two-entry queue. The back end reads the cell from the store and, once the
// output register is free, writes the sum back for an accepted fill item; it takes
// no new item until then, and that read-then-write sets the sustained rate. A result
// is held in the output register until it is taken, while new items can still enter.
module histogram_bin_accumulator
  import hba_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hba_in_if.sink               in_ch,
  hba_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = idx_width(MAX_CELLS);
  localparam int JOB_W = 2 + CELL_W + IDX_W;

  hba_cfg_t   cfg_r, cfg_nxt;
  hba_bstat_t bstat;

  logic             push_valid, push_ready;
  logic [JOB_W-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [JOB_W-1:0] pop_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (hba_reg_t'(cfg_index))
        REG_ENABLE:     cfg_nxt.enable     = cfg_wdata[0];
        REG_HIST_ID:    cfg_nxt.hist_id    = cfg_wdata[ID_W-1:0];
        REG_TWO_DIM:    cfg_nxt.two_dim    = cfg_wdata[0];
        REG_X_BINS:     cfg_nxt.x_bins     = cfg_wdata[AXIS_W-1:0];
        REG_Y_BINS:     cfg_nxt.y_bins     = cfg_wdata[AXIS_W-1:0];
        REG_WIDE_CELLS: cfg_nxt.wide_cells = cfg_wdata[0];
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable     <= 1'b0;
      cfg_r.hist_id    <= '0;
      cfg_r.two_dim    <= 1'b0;
      cfg_r.x_bins     <= AXIS_W'(16384);
      cfg_r.y_bins     <= AXIS_W'(1);
      cfg_r.wide_cells <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hba_front #(
    .MAX_CELLS (MAX_CELLS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .bstat      (bstat),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  hba_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  hba_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .bstat     (bstat),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

### rtl/hba_chk.sv
module hba_chk
  import hba_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_accepted,
  input logic [CELL_W-1:0] out_cell_value
);

  logic [2:0] cnt_r, cnt_nxt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r + 3'(in_xfer) - 3'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // The store is cleared after every reset before any item is taken.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted) && $stable(out_cell_value))
    else $error("stalled result changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_cell_value == '0)
    else $error("rejected item with nonzero value");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 3'd0)
    else $error("result without an outstanding item");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd5)
    else $error("too many items in flight");

endmodule

bind histogram_bin_accumulator hba_chk u_hba_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_accepted   (out_ch.accepted),
  .out_cell_value (out_ch.cell_value)
);
